// ===== hdl/fud_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fud_pkg
// Types, character codes and helpers shared by the form body decoder.
// ----------------------------------------------------------------------------
package fud_pkg;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_AMP   = 8'h26;
	localparam logic [7:0] CHAR_EQ    = 8'h3D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_NAME  = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ESC_NONE  = 2'd0,
		ESC_PCT   = 2'd1,
		ESC_DIGIT = 2'd2
	} esc_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      out_kind;
		logic       run_last;
		logic       form_done;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} batch_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			h.val = c[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/fud_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fud_if
// Valid/ready stream interfaces for the raw body bytes and decoded results.
// ----------------------------------------------------------------------------
interface fud_body_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       final_byte;

	modport source (output valid, output in_byte, output final_byte, input ready);
	modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

interface fud_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] out_kind;
	logic       run_last;
	logic       form_done;

	modport source (output valid, output out_byte, output out_kind, output run_last,
		output form_done, input ready);
	modport sink (input valid, input out_byte, input out_kind, input run_last,
		input form_done, output ready);
endinterface
`default_nettype wire

// ===== hdl/fud_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fud_decode
// Pair and escape state, and the results produced by one accepted body byte.
// ----------------------------------------------------------------------------
module fud_decode import fud_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] in_byte,
	input  wire logic       final_byte,
	output batch_t          batch
);

	logic       value_q;
	esc_t       esc_q;
	logic [3:0] nib_q;
	logic       nib_ok_q;

	logic       value_d;
	esc_t       esc_d;
	logic [3:0] nib_d;
	logic       nib_ok_d;

	logic       emit_v;
	logic [7:0] emit_byte;
	kind_t      emit_kind;
	logic       pad_v;
	logic       end_v;
	logic       end_done;
	hex_t       hex;
	result_t    slot_a;
	result_t    slot_end;

	always_comb begin
		hex       = hex_digit(in_byte);
		value_d   = value_q;
		esc_d     = esc_q;
		nib_d     = nib_q;
		nib_ok_d  = nib_ok_q;
		emit_v    = 1'b0;
		emit_byte = in_byte;
		emit_kind = KIND_VALUE;
		pad_v     = 1'b0;
		end_v     = 1'b0;
		end_done  = 1'b1;

		if (in_byte == CHAR_AMP) begin
			pad_v    = (esc_q != ESC_NONE);
			end_v    = 1'b1;
			end_done = final_byte;
		end else begin
			if (!value_q) begin
				if (in_byte == CHAR_EQ) begin
					value_d = 1'b1;
				end else begin
					emit_v    = 1'b1;
					emit_kind = KIND_NAME;
				end
			end else begin
				unique case (esc_q)
					ESC_PCT: begin
						nib_ok_d = hex.ok;
						nib_d    = hex.val;
						esc_d    = ESC_DIGIT;
					end
					ESC_DIGIT: begin
						emit_v    = 1'b1;
						emit_byte = (hex.ok && nib_ok_q) ? {nib_q, hex.val} : 8'h00;
						esc_d     = ESC_NONE;
						nib_d     = 4'd0;
						nib_ok_d  = 1'b0;
					end
					default: begin
						priority if (in_byte == CHAR_PCT) begin
							esc_d = ESC_PCT;
						end else if (in_byte == CHAR_PLUS) begin
							emit_v    = 1'b1;
							emit_byte = CHAR_SPACE;
						end else begin
							emit_v = 1'b1;
						end
					end
				endcase
			end
			if (final_byte) begin
				pad_v = (esc_d != ESC_NONE);
				end_v = 1'b1;
			end
		end

		if (end_v) begin
			value_d  = 1'b0;
			esc_d    = ESC_NONE;
			nib_d    = 4'd0;
			nib_ok_d = 1'b0;
		end

		slot_a.out_byte  = emit_v ? emit_byte : 8'h00;
		slot_a.out_kind  = emit_v ? emit_kind : KIND_VALUE;
		slot_a.run_last  = !end_v;
		slot_a.form_done = 1'b0;

		slot_end.out_byte  = 8'h00;
		slot_end.out_kind  = KIND_END;
		slot_end.run_last  = 1'b1;
		slot_end.form_done = end_done;

		batch.second = slot_end;
		if (emit_v || pad_v) begin
			batch.first = slot_a;
			batch.count = end_v ? 2'd2 : 2'd1;
		end else begin
			batch.first = slot_end;
			batch.count = end_v ? 2'd1 : 2'd0;
		end
		if (!accept) begin
			batch.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q  <= 1'b0;
			esc_q    <= ESC_NONE;
			nib_q    <= 4'd0;
			nib_ok_q <= 1'b0;
		end else if (accept) begin
			value_q  <= value_d;
			esc_q    <= esc_d;
			nib_q    <= nib_d;
			nib_ok_q <= nib_ok_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/fud_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fud_queue
// Result queue that takes up to two results per cycle and gives one per beat.
// ----------------------------------------------------------------------------
module fud_queue import fud_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire batch_t batch,
	input  wire logic   pop,
	output logic        space,
	output logic        head_valid,
	output result_t     head
);

	result_t            mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_pop;

	assign head_valid = (count_q != '0);
	assign head       = mem[rd_ptr_q];
	assign space      = (count_q <= CNT_W'(QUEUE_DEPTH - 2));
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (batch.count != 2'd0) begin
			mem[wr_ptr_q] <= batch.first;
		end
		if (batch.count == 2'd2) begin
			mem[wr_ptr_q + PTR_W'(1)] <= batch.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(batch.count);
			rd_ptr_q <= rd_ptr_q + PTR_W'(do_pop);
			count_q  <= count_q + CNT_W'(batch.count) - CNT_W'(do_pop);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("result queue holds more than its depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(batch.count != 2'd0) |-> space)
		else $error("results written while the queue lacks room");

	a_run_whole: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !head.run_last) |-> (count_q >= CNT_W'(2)))
		else $error("run continues but its next result is missing");
`endif

endmodule
`default_nettype wire

// ===== hdl/form_urlencoded_decoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// form_urlencoded_decoder_top
// Decodes a form-encoded body into tagged name bytes, value bytes and pair ends.
//
//   Channel   Role     Beat
//   body      sink     in_byte, final_byte
//   result    source   out_byte, out_kind, run_last, form_done
//
// One body beat is taken per cycle while the result queue has room for two.
// A byte is decoded in the cycle it is taken; its results are registered into the result queue.
// Each body beat gives zero to two result beats, one result beat per cycle while result.ready is high.
// Reset clears the pair and escape state and empties the queue.
// A stalled result side fills the four-entry queue until fewer than two entries are free, then holds off body beats.
// ----------------------------------------------------------------------------
module form_urlencoded_decoder_top import fud_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	fud_body_if.sink      body,
	fud_result_if.source  result
);

	batch_t  batch;
	result_t head;
	logic    space;
	logic    head_valid;
	logic    accept;

	assign body.ready = space;
	assign accept     = body.valid && space;

	fud_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (body.in_byte),
		.final_byte (body.final_byte),
		.batch      (batch)
	);

	fud_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.batch      (batch),
		.pop        (result.ready),
		.space      (space),
		.head_valid (head_valid),
		.head       (head)
	);

	assign result.valid     = head_valid;
	assign result.out_byte  = head.out_byte;
	assign result.out_kind  = head.out_kind;
	assign result.run_last  = head.run_last;
	assign result.form_done = head.form_done;

endmodule
`default_nettype wire
